### design/bq_pkg.sv
// ----------------------------------------------------------------------------
// bq_pkg
// Shared constants, types and control bundle for the biquad filter core.
// ----------------------------------------------------------------------------
package bq_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_BITS      = 28;
	localparam int COEF_FRAC_BITS = 24;
	localparam int DELAY_BITS     = 56;
	localparam int MAX_CHANNELS   = 8;
	localparam int CHAN_BITS      = 3;
	localparam int CH_IDX_BITS    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NUM_REGS       = 5;
	localparam int REG_IDX_BITS   = 3;
	localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
	localparam int ACC_BITS       = DELAY_BITS + 2;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_A1 = 3'd3,
		REG_A2 = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		CS_B0,
		CS_B1,
		CS_B2,
		CS_A1,
		CS_A2
	} coef_sel_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] b0;
		logic signed [COEF_BITS-1:0] b1;
		logic signed [COEF_BITS-1:0] b2;
		logic signed [COEF_BITS-1:0] a1;
		logic signed [COEF_BITS-1:0] a2;
	} coef_set_t;

	typedef struct packed {
		logic      load_in;
		logic      mul_en;
		coef_sel_t coef_sel;
		logic      mul_use_in;
		logic      ld_y;
		logic      ld_acc;
		logic      acc_add_z2;
		logic      wr_d1;
		logic      wr_d2;
		logic      ld_out;
	} ctrl_t;

endpackage

### design/bq_coef_regs.sv
// ----------------------------------------------------------------------------
// bq_coef_regs
// Coefficient register file, written through the plain configuration port.
// ----------------------------------------------------------------------------
module bq_coef_regs import bq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [REG_IDX_BITS-1:0] cfg_index,
	input  logic [COEF_BITS-1:0]    cfg_data,
	output coef_set_t               coef
);

	coef_set_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= COEF_BITS'(1) << COEF_FRAC_BITS;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_B0:  coef_q.b0 <= cfg_data;
				REG_B1:  coef_q.b1 <= cfg_data;
				REG_B2:  coef_q.b2 <= cfg_data;
				REG_A1:  coef_q.a1 <= cfg_data;
				REG_A2:  coef_q.a2 <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

### design/bq_ctrl.sv
// ----------------------------------------------------------------------------
// bq_ctrl
// Sequencer: steps the shared multiplier through the five products of one
// sample and owns the input/output handshakes.
// ----------------------------------------------------------------------------
module bq_ctrl import bq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	output ctrl_t ctrl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_B1,
		S_A1,
		S_B2,
		S_A2,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			S_IDLE: begin
				ctrl.load_in    = in_valid;
				ctrl.mul_en     = in_valid;
				ctrl.mul_use_in = 1'b1;
				ctrl.coef_sel   = CS_B0;
			end
			S_B1: begin
				ctrl.ld_y     = 1'b1;
				ctrl.mul_en   = 1'b1;
				ctrl.coef_sel = CS_B1;
			end
			S_A1: begin
				ctrl.ld_acc     = 1'b1;
				ctrl.acc_add_z2 = 1'b1;
				ctrl.mul_en     = 1'b1;
				ctrl.coef_sel   = CS_A1;
			end
			S_B2: begin
				ctrl.wr_d1    = 1'b1;
				ctrl.mul_en   = 1'b1;
				ctrl.coef_sel = CS_B2;
			end
			S_A2: begin
				ctrl.ld_acc   = 1'b1;
				ctrl.mul_en   = 1'b1;
				ctrl.coef_sel = CS_A2;
			end
			S_FIN: begin
				ctrl.wr_d2  = out_free;
				ctrl.ld_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_B1;
				S_B1:    state_q <= S_A1;
				S_A1:    state_q <= S_B2;
				S_B2:    state_q <= S_A2;
				S_A2:    state_q <= S_FIN;
				S_FIN:   if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### design/bq_datapath.sv
// ----------------------------------------------------------------------------
// bq_datapath
// Shared multiplier, accumulator, saturation and per-channel delay terms.
// ----------------------------------------------------------------------------
module bq_datapath import bq_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctrl_t                         ctrl,
	input  coef_set_t                     coef,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [CHAN_BITS-1:0]          channel,
	input  logic                          restart,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic [CHAN_BITS-1:0]          channel_out
);

	localparam int YSUM_BITS = DELAY_BITS + 1;

	localparam logic signed [YSUM_BITS-1:0] Y_MAX =
		{{(YSUM_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [YSUM_BITS-1:0] Y_MIN = ~Y_MAX;
	localparam logic signed [ACC_BITS-1:0] D_MAX =
		{{(ACC_BITS-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] D_MIN = ~D_MAX;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic [CHAN_BITS-1:0]          ch_q;
	logic                          restart_q;
	logic signed [PROD_BITS-1:0]   prod_q;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic [CHAN_BITS-1:0]          channel_out_q;
	logic signed [DELAY_BITS-1:0]  d1_q [MAX_CHANNELS];
	logic signed [DELAY_BITS-1:0]  d2_q [MAX_CHANNELS];

	logic [CH_IDX_BITS-1:0]        ch_idx;
	logic signed [COEF_BITS-1:0]   mul_coef;
	logic signed [SAMPLE_BITS-1:0] mul_op;
	logic signed [PROD_BITS-1:0]   prod_d;
	logic signed [DELAY_BITS-1:0]  z1;
	logic signed [DELAY_BITS-1:0]  z2;
	logic signed [YSUM_BITS-1:0]   ysum;
	logic signed [YSUM_BITS-1:0]   yshift;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic signed [ACC_BITS-1:0]    acc_d;
	logic signed [ACC_BITS-1:0]    diff;
	logic signed [DELAY_BITS-1:0]  d_sat;

	assign ch_idx = ch_q[CH_IDX_BITS-1:0];
	assign z1     = restart_q ? '0 : d1_q[ch_idx];
	assign z2     = restart_q ? '0 : d2_q[ch_idx];

	always_comb begin
		case (ctrl.coef_sel)
			CS_B0:   mul_coef = coef.b0;
			CS_B1:   mul_coef = coef.b1;
			CS_B2:   mul_coef = coef.b2;
			CS_A1:   mul_coef = coef.a1;
			CS_A2:   mul_coef = coef.a2;
			default: mul_coef = '0;
		endcase
		if (ctrl.mul_use_in) begin
			mul_op = sample_in;
		end else if (ctrl.coef_sel == CS_A1 || ctrl.coef_sel == CS_A2) begin
			mul_op = y_q;
		end else begin
			mul_op = x_q;
		end
	end

	assign prod_d = PROD_BITS'(mul_coef) * PROD_BITS'(mul_op);

	// output: floor shift of b0*x + z1, then clamp to the sample range
	assign ysum   = YSUM_BITS'(prod_q) + YSUM_BITS'(z1);
	assign yshift = ysum >>> COEF_FRAC_BITS;

	always_comb begin
		if (yshift > Y_MAX) begin
			y_sat = Y_MAX[SAMPLE_BITS-1:0];
		end else if (yshift < Y_MIN) begin
			y_sat = Y_MIN[SAMPLE_BITS-1:0];
		end else begin
			y_sat = yshift[SAMPLE_BITS-1:0];
		end
	end

	assign acc_d = ctrl.acc_add_z2 ? (ACC_BITS'(prod_q) + ACC_BITS'(z2)) : ACC_BITS'(prod_q);
	assign diff  = acc_q - ACC_BITS'(prod_q);

	always_comb begin
		if (diff > D_MAX) begin
			d_sat = D_MAX[DELAY_BITS-1:0];
		end else if (diff < D_MIN) begin
			d_sat = D_MIN[DELAY_BITS-1:0];
		end else begin
			d_sat = diff[DELAY_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			x_q       <= sample_in;
			ch_q      <= channel;
			restart_q <= restart;
		end
		if (ctrl.mul_en) begin
			prod_q <= prod_d;
		end
		if (ctrl.ld_y) begin
			y_q <= y_sat;
		end
		if (ctrl.ld_acc) begin
			acc_q <= acc_d;
		end
		if (ctrl.ld_out) begin
			sample_out_q  <= y_q;
			channel_out_q <= ch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else begin
			if (ctrl.wr_d1) begin
				d1_q[ch_idx] <= d_sat;
			end
			if (ctrl.wr_d2) begin
				d2_q[ch_idx] <= d_sat;
			end
		end
	end

	assign sample_out  = sample_out_q;
	assign channel_out = channel_out_q;

endmodule

### design/biquad_iir_filter_core.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter_core
// Transposed direct form II biquad over interleaved multichannel audio.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one signed sample, its channel number
//   and a restart flag per transaction. Restart zeroes that channel's two
//   delay terms before the sample is filtered.
//   Output channel (out_valid/out_ready): filtered sample, saturated to the
//   sample width, with the raw channel number echoed.
//   Configuration: cfg_wr_en/cfg_index/cfg_data write one coefficient
//   (b0, b1, b2, a1, a2) per write; unknown indexes are ignored. Write
//   only while no transaction is in flight.
//   After an input transaction the sequencer steps through B1, A1, B2,
//   A2 and FIN, setting out_valid as it leaves FIN. One multiplier is
//   shared by the five products, one product per cycle, plus the final
//   delay update. in_ready is high only while the sequencer is idle.
//   Receiver stall: a finished result waits in the output register while
//   the next sample is taken; the sequencer then holds in its last step
//   until the output register frees up.
//   Reset: coefficients return to b0 = 1.0 and the rest zero, all delay
//   terms clear at once, and no result is pending.
// ----------------------------------------------------------------------------
module biquad_iir_filter_core import bq_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [REG_IDX_BITS-1:0]       cfg_index,
	input  logic [COEF_BITS-1:0]          cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [CHAN_BITS-1:0]          channel,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic [CHAN_BITS-1:0]          channel_out
);

	coef_set_t coef;
	ctrl_t     ctrl;

	bq_coef_regs u_coef_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	bq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	bq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.coef        (coef),
		.sample_in   (sample_in),
		.channel     (channel),
		.restart     (restart),
		.sample_out  (sample_out),
		.channel_out (channel_out)
	);

endmodule

### design/bq_checker.sv
// ----------------------------------------------------------------------------
// bq_checker
// Port-level checks on the biquad core, bound to the top level.
// ----------------------------------------------------------------------------
module bq_checker import bq_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] sample_out,
	input logic [CHAN_BITS-1:0]          channel_out
);

	// sequencer stays busy for the product steps after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("in_ready returned early after input transaction");

	// no result can appear in the cycles right after an input transaction
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result appeared too soon after input transaction");

	// a new result only shows up as the sequencer returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && !$past(in_ready))
		else $error("result raised outside end of sequence");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(sample_out)
			&& $stable(channel_out))
		else $error("stalled output transaction changed");

endmodule

bind biquad_iir_filter_core bq_checker u_bq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.sample_out  (sample_out),
	.channel_out (channel_out)
);
